@@ sv/ppv_pkg.sv @@
// Shared types and constants for the perspective projection vertex block.
// No dependencies; every other file refers to it by scoped names.
package ppv_pkg;

    localparam int DATA_W        = 32;
    localparam int CFG_W         = 31;
    localparam int QUOT_BITS     = 32;   // quotient bits resolved by the cell chain
    localparam int NUM_LANES     = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam int FAR_RESET_INT = 100;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_W = 2;

    typedef enum logic [1:0] {
        REG_NEAR   = 2'd0,
        REG_FAR    = 2'd1,
        REG_TEXCOR = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] near_plane;
        logic [CFG_W-1:0] far_plane;
        logic             texture_correct;
    } t_cfg;

    // One divider lane: partial remainder, plus dividend bits shifting out
    // while quotient bits shift in.
    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] nq;
        logic              neg;
        logic              ovf;
    } t_lane;

    typedef struct packed {
        logic                     vld;
        t_lane [NUM_LANES-1:0]    lane;
        logic [DATA_W-1:0]        dvsr;
        logic                     zero;
        logic                     last;
        logic [DATA_W-1:0]        s;
        logic [DATA_W-1:0]        t;
    } t_div_stage;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] t;
        logic              zero;
        logic              last;
    } t_result;

endpackage

@@ sv/ppv_vtx_if.sv @@
// Vertex input channel: valid/ready handshake with the vertex fields.
// Uses ppv_pkg for widths.
interface ppv_vtx_if;
    logic                          valid;
    logic                          ready;
    logic [ppv_pkg::DATA_W-1:0]    x_in;
    logic [ppv_pkg::DATA_W-1:0]    y_in;
    logic [ppv_pkg::DATA_W-1:0]    z_in;
    logic [ppv_pkg::DATA_W-1:0]    w_in;
    logic [ppv_pkg::DATA_W-1:0]    s_in;
    logic [ppv_pkg::DATA_W-1:0]    t_in;
    logic                          last_in;

    modport source (output valid, x_in, y_in, z_in, w_in, s_in, t_in, last_in, input ready);
    modport sink   (input valid, x_in, y_in, z_in, w_in, s_in, t_in, last_in, output ready);
endinterface

@@ sv/ppv_res_if.sv @@
// Projected vertex output channel: valid/ready handshake with result fields.
// Uses ppv_pkg for widths.
interface ppv_res_if;
    logic                          valid;
    logic                          ready;
    logic [ppv_pkg::DATA_W-1:0]    x_out;
    logic [ppv_pkg::DATA_W-1:0]    y_out;
    logic [ppv_pkg::DATA_W-1:0]    z_out;
    logic [ppv_pkg::DATA_W-1:0]    s_out;
    logic [ppv_pkg::DATA_W-1:0]    t_out;
    logic                          zero_depth;
    logic                          last_out;

    modport source (output valid, x_out, y_out, z_out, s_out, t_out, zero_depth, last_out,
                    input ready);
    modport sink   (input valid, x_out, y_out, z_out, s_out, t_out, zero_depth, last_out,
                    output ready);
endinterface

@@ sv/ppv_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit on each of the lanes.
// Uses ppv_pkg stage types.
module ppv_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ppv_pkg::t_div_stage i_stage,
    output ppv_pkg::t_div_stage o_stage
);

    ppv_pkg::t_div_stage r_stage;
    ppv_pkg::t_div_stage n_stage;

    always_comb begin
        logic [ppv_pkg::DATA_W:0] trial;
        logic                     qbit;
        n_stage = i_stage;
        for (int l = 0; l < ppv_pkg::NUM_LANES; l++) begin
            trial = {i_stage.lane[l].rem, i_stage.lane[l].nq[ppv_pkg::DATA_W-1]};
            qbit  = (trial >= {1'b0, i_stage.dvsr});
            n_stage.lane[l].rem = qbit ? ppv_pkg::DATA_W'(trial - {1'b0, i_stage.dvsr})
                                       : trial[ppv_pkg::DATA_W-1:0];
            n_stage.lane[l].nq  = {i_stage.lane[l].nq[ppv_pkg::DATA_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ sv/ppv_cfg.sv @@
// APB register file: near plane, far plane, texture correction enable.
// Uses ppv_pkg register codes and config struct.
module ppv_cfg #(
    parameter int P_FRAC_BITS = ppv_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ppv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ppv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output ppv_pkg::t_cfg                     o_cfg
);

    ppv_pkg::t_cfg    r_cfg;
    ppv_pkg::t_reg_idx idx;
    logic             wr;

    assign idx    = ppv_pkg::t_reg_idx'(paddr[ppv_pkg::APB_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_plane      <= ppv_pkg::CFG_W'(1 << P_FRAC_BITS);
            r_cfg.far_plane       <= ppv_pkg::CFG_W'(ppv_pkg::FAR_RESET_INT << P_FRAC_BITS);
            r_cfg.texture_correct <= 1'b0;
        end else if (wr) begin
            unique case (idx)
                ppv_pkg::REG_NEAR:   r_cfg.near_plane      <= pwdata[ppv_pkg::CFG_W-1:0];
                ppv_pkg::REG_FAR:    r_cfg.far_plane       <= pwdata[ppv_pkg::CFG_W-1:0];
                ppv_pkg::REG_TEXCOR: r_cfg.texture_correct <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ppv_pkg::REG_NEAR:   prdata = {1'b0, r_cfg.near_plane};
            ppv_pkg::REG_FAR:    prdata = {1'b0, r_cfg.far_plane};
            ppv_pkg::REG_TEXCOR: prdata = {{(ppv_pkg::APB_DATA_W-1){1'b0}},
                                           r_cfg.texture_correct};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ sv/ppv_out_skid.sv @@
// Output register with a skid stage, so the pipeline keeps moving while a
// result waits. Uses ppv_pkg result struct and the ppv_res_if channel.
module ppv_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_up_vld,
    input  ppv_pkg::t_result  i_up_data,
    output logic              o_up_ready,
    ppv_res_if.source         m_res
);

    ppv_pkg::t_result r_out;
    ppv_pkg::t_result r_skid;
    logic             r_out_vld;
    logic             r_skid_vld;

    assign o_up_ready = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (m_res.ready) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (i_up_vld) begin
            if (!r_out_vld || m_res.ready) begin
                r_out     <= i_up_data;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= i_up_data;
                r_skid_vld <= 1'b1;
            end
        end else if (m_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_res.valid      = r_out_vld;
    assign m_res.x_out      = r_out.x;
    assign m_res.y_out      = r_out.y;
    assign m_res.z_out      = r_out.z;
    assign m_res.s_out      = r_out.s;
    assign m_res.t_out      = r_out.t;
    assign m_res.zero_depth = r_out.zero;
    assign m_res.last_out   = r_out.last;

endmodule

@@ sv/perspective_project_vertex.sv @@
// Top level: perspective projection with homogeneous divide, one vertex a beat.
// Uses ppv_pkg, ppv_vtx_if, ppv_res_if, ppv_cfg, ppv_div_cell, ppv_out_skid.
//
//  channel   dir  handshake                  payload
//  s_vtx     in   valid/ready                x,y,z,w,s,t (Q16.16), last
//  m_res     out  valid/ready                x,y,z,s,t (Q16.16), zero_depth, last
//  apb       in   psel/penable/pwrite/pready near, far, texture_correct
//
// Accepts one beat per cycle while the skid stage is empty; an accepted beat passes the
// registers in order (multiply, operand prep, 32 division cells of one quotient bit each,
// quotient saturation, texture multiply) and texture scaling feeds the output register.
// Synchronous active-low reset clears valid bits and loads register defaults.
// The whole pipeline holds only while the skid stage is occupied.
module perspective_project_vertex #(
    parameter int P_FRAC_BITS = ppv_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ppv_vtx_if.sink                           s_vtx,
    ppv_res_if.source                         m_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppv_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ppv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ppv_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int W = ppv_pkg::DATA_W;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    ppv_pkg::t_cfg cfg;
    logic          en;

    ppv_cfg #(.P_FRAC_BITS(P_FRAC_BITS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign s_vtx.ready = en;

    // ---------------- stage 1: products ----------------
    logic signed [W-1:0]   near_s, span_s;
    logic signed [2*W-1:0] n_px, n_py, n_pw;
    logic signed [2*W-1:0] r_px, r_py, r_pw;
    logic [W-1:0]          r_z1, r_s1, r_t1;
    logic                  r_last1, r_vld1;

    assign near_s = $signed({1'b0, cfg.near_plane});
    assign span_s = $signed({1'b0, cfg.far_plane}) - $signed({1'b0, cfg.near_plane});
    assign n_px   = $signed(s_vtx.x_in) * near_s;
    assign n_py   = $signed(s_vtx.y_in) * near_s;
    assign n_pw   = $signed(s_vtx.w_in) * span_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (en) begin
            r_vld1  <= s_vtx.valid;
            r_px    <= n_px;
            r_py    <= n_py;
            r_pw    <= n_pw;
            r_z1    <= s_vtx.z_in;
            r_s1    <= s_vtx.s_in;
            r_t1    <= s_vtx.t_in;
            r_last1 <= s_vtx.last_in;
        end
    end

    // ---------------- stage 2: magnitudes, overflow pre-check ----------------
    ppv_pkg::t_div_stage chain [0:ppv_pkg::QUOT_BITS];
    ppv_pkg::t_div_stage n_prep, r_prep;

    always_comb begin
        logic [2*W-1:0] prod [ppv_pkg::NUM_LANES];
        logic [2*W-1:0] mag;
        logic [W-1:0]   dv;
        prod[ppv_pkg::LANE_X] = r_px;
        prod[ppv_pkg::LANE_Y] = r_py;
        prod[ppv_pkg::LANE_W] = r_pw;
        dv = r_z1[W-1] ? W'(-r_z1) : r_z1;
        n_prep      = '0;
        n_prep.vld  = r_vld1;
        n_prep.dvsr = dv;
        n_prep.zero = (r_z1 == '0);
        n_prep.last = r_last1;
        n_prep.s    = r_s1;
        n_prep.t    = r_t1;
        for (int l = 0; l < ppv_pkg::NUM_LANES; l++) begin
            mag = prod[l][2*W-1] ? (2*W)'(-prod[l]) : prod[l];
            n_prep.lane[l].rem = mag[2*W-1:W];
            n_prep.lane[l].nq  = mag[W-1:0];
            n_prep.lane[l].ovf = (mag[2*W-1:W] >= dv);
            n_prep.lane[l].neg = prod[l][2*W-1] ^ r_z1[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.vld <= 1'b0;
        end else if (en) begin
            r_prep <= n_prep;
        end
    end

    assign chain[0] = r_prep;

    // ---------------- division cell chain ----------------
    for (genvar g = 0; g < ppv_pkg::QUOT_BITS; g++) begin : g_cell
        ppv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    // ---------------- stage: quotient sign and saturation ----------------
    ppv_pkg::t_div_stage dq;
    logic [W-1:0] n_q [ppv_pkg::NUM_LANES];
    logic [W-1:0] r_qx, r_qy, r_qz, r_qs, r_qt;
    logic         r_qzero, r_qlast, r_qvld;

    assign dq = chain[ppv_pkg::QUOT_BITS];

    always_comb begin
        logic [W-1:0] q;
        for (int l = 0; l < ppv_pkg::NUM_LANES; l++) begin
            q = dq.lane[l].nq;
            if (dq.zero) begin
                n_q[l] = '0;
            end else if (dq.lane[l].neg) begin
                n_q[l] = (dq.lane[l].ovf || q > SMIN) ? SMIN : W'(-q);
            end else begin
                n_q[l] = (dq.lane[l].ovf || q[W-1]) ? SMAX : q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qvld <= 1'b0;
        end else if (en) begin
            r_qvld  <= dq.vld;
            r_qx    <= n_q[ppv_pkg::LANE_X];
            r_qy    <= n_q[ppv_pkg::LANE_Y];
            r_qz    <= n_q[ppv_pkg::LANE_W];
            r_qs    <= dq.s;
            r_qt    <= dq.t;
            r_qzero <= dq.zero;
            r_qlast <= dq.last;
        end
    end

    // ---------------- stage: texture magnitude products ----------------
    logic [W-1:0]   zmag, smag, tmag;
    logic [2*W-1:0] r_ms, r_mt;
    logic           r_sneg, r_tneg;
    logic [W-1:0]   r_mx, r_my, r_mz, r_rs, r_rt;
    logic           r_mzero, r_mlast, r_mvld;

    assign zmag = r_qz[W-1] ? W'(-r_qz) : r_qz;
    assign smag = r_qs[W-1] ? W'(-r_qs) : r_qs;
    assign tmag = r_qt[W-1] ? W'(-r_qt) : r_qt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (en) begin
            r_mvld  <= r_qvld;
            r_ms    <= smag * zmag;
            r_mt    <= tmag * zmag;
            r_sneg  <= r_qs[W-1] ^ r_qz[W-1];
            r_tneg  <= r_qt[W-1] ^ r_qz[W-1];
            r_mx    <= r_qx;
            r_my    <= r_qy;
            r_mz    <= r_qz;
            r_rs    <= r_qs;
            r_rt    <= r_qt;
            r_mzero <= r_qzero;
            r_mlast <= r_qlast;
        end
    end

    // ---------------- scaling, saturation, select into the skid stage ----------------
    ppv_pkg::t_result res;

    function automatic logic [ppv_pkg::DATA_W-1:0] sat_frac(
        input logic [2*ppv_pkg::DATA_W-1:0] p,
        input logic                         neg
    );
        logic [ppv_pkg::DATA_W-1:0] mx, mn;
        mx = {1'b0, {(ppv_pkg::DATA_W-1){1'b1}}};
        mn = {1'b1, {(ppv_pkg::DATA_W-1){1'b0}}};
        if (neg) begin
            sat_frac = (p > (2*ppv_pkg::DATA_W)'(mn)) ? mn : ppv_pkg::DATA_W'(-p);
        end else begin
            sat_frac = (p >= (2*ppv_pkg::DATA_W)'(mn)) ? mx : p[ppv_pkg::DATA_W-1:0];
        end
    endfunction

    always_comb begin
        logic [2*W-1:0] ps, pt;
        ps = r_ms >> P_FRAC_BITS;
        pt = r_mt >> P_FRAC_BITS;
        res.x    = r_mx;
        res.y    = r_my;
        res.z    = r_mz;
        res.zero = r_mzero;
        res.last = r_mlast;
        if (r_mzero) begin
            res.s = '0;
            res.t = '0;
        end else if (cfg.texture_correct) begin
            res.s = sat_frac(ps, r_sneg);
            res.t = sat_frac(pt, r_tneg);
        end else begin
            res.s = r_rs;
            res.t = r_rt;
        end
    end

    ppv_out_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_vld   (r_mvld && en),
        .i_up_data  (res),
        .o_up_ready (en),
        .m_res      (m_res)
    );

endmodule
